>>> hdl/kmer_pkg.sv
// ----------------------------------------------------------------------------
// kmer_pkg: shared types and constants for the k-mer encoder
// Holds the 2-bit base codes, the length limits and the ASCII decode function.
// ----------------------------------------------------------------------------
package kmer_pkg;

    typedef logic [1:0] base_code_t;
    typedef logic [5:0] kmer_len_t;

    typedef struct packed {
        logic       ok;
        base_code_t code;
    } base_decode_t;

    // Longest k-mer that still gives codes, and the saturated "overlong" count
    localparam int        MAX_K      = 32;
    localparam kmer_len_t MAX_LEN    = 6'(MAX_K);
    localparam kmer_len_t LEN_SAT    = 6'(MAX_K + 1);
    localparam int        CODE_BITS  = 64;
    localparam int        PAIRS      = CODE_BITS / 2;

    localparam base_code_t CODE_A = 2'd3;
    localparam base_code_t CODE_C = 2'd2;
    localparam base_code_t CODE_G = 2'd1;
    localparam base_code_t CODE_T = 2'd0;

    localparam logic [7:0] ASCII_A_UP = 8'h41;
    localparam logic [7:0] ASCII_C_UP = 8'h43;
    localparam logic [7:0] ASCII_G_UP = 8'h47;
    localparam logic [7:0] ASCII_T_UP = 8'h54;
    localparam logic [7:0] ASCII_A_LO = 8'h61;
    localparam logic [7:0] ASCII_C_LO = 8'h63;
    localparam logic [7:0] ASCII_G_LO = 8'h67;
    localparam logic [7:0] ASCII_T_LO = 8'h74;

    // Map a character to its base code; anything else decodes as T, not ok
    function automatic base_decode_t decode_base(input logic [7:0] ch);
        base_decode_t d;
        d.ok   = 1'b1;
        d.code = CODE_T;
        unique case (ch) inside
            ASCII_A_UP, ASCII_A_LO: d.code = CODE_A;
            ASCII_C_UP, ASCII_C_LO: d.code = CODE_C;
            ASCII_G_UP, ASCII_G_LO: d.code = CODE_G;
            ASCII_T_UP, ASCII_T_LO: d.code = CODE_T;
            default:                d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/kmer_encode_reverse_complement.sv
// ----------------------------------------------------------------------------
// kmer_encode_reverse_complement: streaming 2-bit k-mer encoder
// Packs one nucleotide character per item and, on the last one, reports the
// forward code, the reverse complement, the length and an error flag.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  item     | in        | item_valid / item_stall   | symbol[7:0], last
//  result   | out       | result_valid/result_stall | forward_code[63:0],
//           |           |                           | reverse_code[63:0],
//           |           |                           | kmer_length[5:0], error
//
//  One item is taken per cycle unless stalled; a result appears in the cycle after its last item.
//  The rate is set by the single result register: the input stalls only while
//  that register holds a result that the consumer is stalling.
//  Reset (rst_n low, asynchronous) clears the k-mer state and the result valid.
//  The reverse complement is built as characters arrive, one pair per item, so
//  the output path has no wide shifter.
//
module kmer_encode_reverse_complement
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  symbol,
    input  logic        last,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] forward_code,
    output logic [63:0] reverse_code,
    output logic [5:0]  kmer_length,
    output logic        error
);

    // k-mer accumulation state
    logic [kmer_pkg::CODE_BITS-1:0] fwd_reg, fwd_next;
    logic [kmer_pkg::CODE_BITS-1:0] rev_reg, rev_next;
    kmer_pkg::kmer_len_t            count_reg, count_next;
    logic                           bad_reg, bad_next;

    // result register
    logic                           res_valid_reg, res_valid_next;
    logic [kmer_pkg::CODE_BITS-1:0] res_fwd_reg, res_rev_reg;
    kmer_pkg::kmer_len_t            res_len_reg;
    logic                           res_err_reg;

    kmer_pkg::base_decode_t         dec;
    logic                           accept;
    logic                           err_now;

    // Stall only when a finished result is still held by the consumer
    assign item_stall = res_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign dec = kmer_pkg::decode_base(symbol);

    // Running values including the current character
    always_comb
    begin
        fwd_next = {fwd_reg[kmer_pkg::CODE_BITS-3:0], dec.code};
        bad_next = bad_reg || !dec.ok;
        if (count_reg < kmer_pkg::LEN_SAT)
        begin
            count_next = count_reg + 6'd1;
        end
        else
        begin
            count_next = count_reg;
        end
        // Drop the complemented code into the pair at the current position;
        // the first character lands lowest, so the result is right aligned
        rev_next = rev_reg;
        for (int i = 0; i < kmer_pkg::PAIRS; i++)
        begin
            if (count_reg == 6'(i))
            begin
                rev_next[2*i +: 2] = ~dec.code;
            end
        end
        err_now = bad_next || (count_next > kmer_pkg::MAX_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            rev_reg   <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                // Clear for the next k-mer
                fwd_reg   <= '0;
                rev_reg   <= '0;
                count_reg <= '0;
                bad_reg   <= 1'b0;
            end
            else
            begin
                fwd_reg   <= fwd_next;
                rev_reg   <= rev_next;
                count_reg <= count_next;
                bad_reg   <= bad_next;
            end
        end
    end

    // Load a new result on a last item, clear it once taken, else hold while stalled
    always_comb
    begin
        if (accept && last)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            res_fwd_reg <= err_now ? '0 : fwd_next;
            res_rev_reg <= err_now ? '0 : rev_next;
            res_len_reg <= count_next;
            res_err_reg <= err_now;
        end
    end

    assign result_valid = res_valid_reg;
    assign forward_code = res_fwd_reg;
    assign reverse_code = res_rev_reg;
    assign kmer_length  = res_len_reg;
    assign error        = res_err_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> res_valid_reg && count_reg == '0 && !bad_reg
                           && fwd_reg == '0 && rev_reg == '0)
        else $error("last item did not produce a result and clear the state");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kmer_pkg::LEN_SAT)
        else $error("character count beyond saturation value");

    a_error_zeroes_codes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_err_reg |-> res_fwd_reg == '0 && res_rev_reg == '0)
        else $error("errored result carries non-zero codes");

    a_good_length_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_err_reg
            |-> res_len_reg != '0 && res_len_reg <= kmer_pkg::MAX_LEN)
        else $error("error-free result with out-of-range length");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> res_valid_reg && !(accept && last))
        else $error("input stalled with no held result");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmer_encode_reverse_complement
// Streams directed and random k-mers through the item channel, predicts each
// result from a local model of the 2-bit packing and the reverse complement,
// and checks every result item field by field. Random idling on both sides
// and one long result hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 2000;
    localparam int CALM_FROM    = 1700;  // no idling past this many items
    localparam int HOLD_AT      = 500;   // start of the long result hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [63:0]         forward;
        logic [63:0]         reverse;
        kmer_pkg::kmer_len_t len;
        logic                err;
    } kmer_result_t;

    // Predict k-mer results from accepted items and check the block's output
    class kmer_checker;
        logic [63:0]         fwd_shift;
        kmer_pkg::kmer_len_t seen;
        logic                bad_seen;
        kmer_result_t        expected_kmers[$];
        int                  mismatches;

        function new();
            fwd_shift  = '0;
            seen       = '0;
            bad_seen   = 1'b0;
            mismatches = 0;
        endfunction

        function void note_item(logic [7:0] ch, logic is_last);
            kmer_pkg::base_code_t code;
            logic                 base_ok;
            logic [63:0]          rc;
            kmer_result_t         r;
            base_ok = 1'b1;
            code    = kmer_pkg::CODE_T;
            case (ch) inside
                kmer_pkg::ASCII_A_UP, kmer_pkg::ASCII_A_LO: code = kmer_pkg::CODE_A;
                kmer_pkg::ASCII_C_UP, kmer_pkg::ASCII_C_LO: code = kmer_pkg::CODE_C;
                kmer_pkg::ASCII_G_UP, kmer_pkg::ASCII_G_LO: code = kmer_pkg::CODE_G;
                kmer_pkg::ASCII_T_UP, kmer_pkg::ASCII_T_LO: code = kmer_pkg::CODE_T;
                default:                                    base_ok = 1'b0;
            endcase
            if (!base_ok)
                bad_seen = 1'b1;
            fwd_shift = {fwd_shift[61:0], code};
            if (seen < kmer_pkg::LEN_SAT)
                seen = seen + 6'd1;
            if (is_last)
            begin
                r.err = bad_seen || (seen > kmer_pkg::MAX_LEN);
                r.len = seen;
                if (r.err)
                begin
                    r.forward = '0;
                    r.reverse = '0;
                end
                else
                begin
                    // newest pair goes in first, so it ends up most significant
                    rc = '0;
                    for (int i = 0; i < seen; i++)
                        rc = {rc[61:0], ~fwd_shift[2*i +: 2]};
                    r.forward = fwd_shift;
                    r.reverse = rc;
                end
                expected_kmers = {expected_kmers, r};
                fwd_shift = '0;
                seen      = '0;
                bad_seen  = 1'b0;
            end
        endfunction

        task report(input string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(input kmer_result_t got);
            kmer_result_t want;
            if (expected_kmers.size() == 0)
            begin
                report("result item with no k-mer outstanding");
            end
            else
            begin
                want = expected_kmers.pop_front();
                if (got.forward !== want.forward)
                    report($sformatf("forward_code %h, want %h", got.forward, want.forward));
                if (got.reverse !== want.reverse)
                    report($sformatf("reverse_code %h, want %h", got.reverse, want.reverse));
                if (got.len !== want.len)
                    report($sformatf("kmer_length %0d, want %0d", got.len, want.len));
                if (got.err !== want.err)
                    report($sformatf("error %b, want %b", got.err, want.err));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [7:0]  symbol;
    logic        last;
    logic        result_valid;
    logic        result_stall;
    logic [63:0] forward_code;
    logic [63:0] reverse_code;
    logic [5:0]  kmer_length;
    logic        error;

    kmer_checker sb;
    int          accepted_items;
    int          cycle_count = 0;
    logic        calm;

    kmer_encode_reverse_complement u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .symbol       (symbol),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .forward_code (forward_code),
        .reverse_code (reverse_code),
        .kmer_length  (kmer_length),
        .error        (error)
    );

    // Free-running clock
    initial
        clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Watchdog: give up if the run stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result monitor: sample at the edge, so values seen are those before it
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result('{forward_code, reverse_code, kmer_length, error});
    end

    // Result receiver: random stall bursts, plus one long hold-off that lets
    // the result register fill and push back on the item channel
    initial
    begin
        result_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (accepted_items >= HOLD_AT && accepted_items < HOLD_AT + 50 && !calm)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                // push past the trigger window so the hold happens once
                wait (accepted_items >= HOLD_AT + 50);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one item; hold the payload until it is taken, then note it
    task send_item(input logic [7:0] ch, input logic is_last);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        symbol     <= ch;
        last       <= is_last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(ch, is_last);
        accepted_items++;
    endtask

    // Send a whole k-mer given as text; the final character carries last
    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_base();
        case ($urandom_range(0, 7))
            0:       return kmer_pkg::ASCII_A_UP;
            1:       return kmer_pkg::ASCII_C_UP;
            2:       return kmer_pkg::ASCII_G_UP;
            3:       return kmer_pkg::ASCII_T_UP;
            4:       return kmer_pkg::ASCII_A_LO;
            5:       return kmer_pkg::ASCII_C_LO;
            6:       return kmer_pkg::ASCII_G_LO;
            default: return kmer_pkg::ASCII_T_LO;
        endcase
    endfunction

    // Mostly short well-formed k-mers; now and then the full 32, an overlong
    // one, or a stray byte in the middle
    task send_random_kmer();
        int         len;
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = kmer_pkg::MAX_K;
        else if (pick == 1)
            len = $urandom_range(kmer_pkg::MAX_K + 1, kmer_pkg::MAX_K + 8);
        else
            len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = random_base();
            send_item(ch, i == len - 1);
        end
    endtask

    initial
    begin
        sb             = new();
        accepted_items = 0;
        calm           = 1'b0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        symbol       <= '0;
        last         <= 1'b0;

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single bases, both cases, an invalid letter mid-k-mer,
        // the two extreme byte values as lone invalid items
        send_text("A");
        send_text("t");
        send_text("ACGT");
        send_text("acgt");
        send_text("GaNc");
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_text("Tt");
        send_text("CgA");

        // Random k-mers; drop idling for the final stretch
        while (accepted_items < ITEM_TARGET)
        begin
            if (accepted_items >= CALM_FROM)
                calm = 1'b1;
            send_random_kmer();
        end
        item_valid <= 1'b0;

        // Drain: wait for every outstanding result, then idle before the report
        while (sb.expected_kmers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
